[src/srta_pkg.sv]
// Package with shared types and constants for the score rank tier assigner.
package srta_pkg;
   localparam int NUM_EXPERTS_DEF = 64;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int SCORE_W = 48;
   localparam int IN_W = 32;
   localparam int ID_W = 6;
   localparam int TIER_W = 2;
   localparam int LOCAL_W = 6;
   localparam int CNT_W = 16;
   localparam int SIZE_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int TCMP_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_VALUES_PER_EXPERT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIER0_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIER1_SIZE = 2'd2;

   localparam logic [TIER_W-1:0] TIER_TOP = 2'd0;
   localparam logic [TIER_W-1:0] TIER_MID = 2'd1;
   localparam logic [TIER_W-1:0] TIER_LOW = 2'd2;

   // Control word broadcast to every cell of the chain.
   typedef struct packed {
      logic push;    // shift a finished score in from the high end
      logic rotate;  // compare against the circulating score, then rotate
      logic emit;    // shift ranks out toward cell zero
   } cell_ctl_type;
endpackage

[src/srta_if.sv]
// Channel interfaces for requests, results and register writes.
interface srta_req_if;
   logic valid;
   logic ready;
   logic [srta_pkg::IN_W-1:0] importance_value;
   modport source (output valid, output importance_value, input ready);
   modport sink (input valid, input importance_value, output ready);
   modport mon (input valid, input importance_value, input ready);
endinterface

interface srta_rsp_if;
   logic valid;
   logic ready;
   logic [srta_pkg::ID_W-1:0] expert_id;
   logic [srta_pkg::TIER_W-1:0] tier;
   logic [srta_pkg::LOCAL_W-1:0] local_index;
   logic last_result;
   modport source (output valid, output expert_id, output tier, output local_index,
                   output last_result, input ready);
   modport sink (input valid, input expert_id, input tier, input local_index,
                 input last_result, output ready);
   modport mon (input valid, input expert_id, input tier, input local_index,
                input last_result, input ready);
endinterface

interface srta_csr_if;
   logic valid;
   logic ready;
   logic [srta_pkg::CSR_IDX_W-1:0] index;
   logic [srta_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
   modport mon (input valid, input index, input data, input ready);
endinterface

[src/srta_cell.sv]
// One chain cell: holds an expert score and id, a circulating copy, and a rank count.
module srta_cell #(
   parameter int RW = 6
) (
   input  logic                           clock,
   input  srta_pkg::cell_ctl_type         ctl,
   input  logic [srta_pkg::SCORE_W-1:0]   score_nb,
   input  logic [RW-1:0]                  id_nb,
   input  logic [srta_pkg::SCORE_W-1:0]   trav_score_nb,
   input  logic [RW-1:0]                  trav_id_nb,
   input  logic [RW-1:0]                  rank_nb,
   output logic [srta_pkg::SCORE_W-1:0]   score,
   output logic [RW-1:0]                  id,
   output logic [srta_pkg::SCORE_W-1:0]   trav_score,
   output logic [RW-1:0]                  trav_id,
   output logic [RW-1:0]                  rank
);
   import srta_pkg::*;

   logic [SCORE_W-1:0] score_ff, trav_score_ff;
   logic [RW-1:0]      id_ff, trav_id_ff, rank_ff;
   logic               beats;

   // The circulating expert outranks this one on a higher score, or on a tie with lower id.
   assign beats = (trav_score_ff > score_ff) ||
                  ((trav_score_ff == score_ff) && (trav_id_ff < id_ff));

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         score_ff      <= score_nb;
         id_ff         <= id_nb;
         trav_score_ff <= score_nb;
         trav_id_ff    <= id_nb;
         rank_ff       <= '0;
      end else if (ctl.rotate) begin
         trav_score_ff <= trav_score_nb;
         trav_id_ff    <= trav_id_nb;
         if (beats) begin
            rank_ff <= rank_ff + 1'b1;
         end
      end else if (ctl.emit) begin
         rank_ff <= rank_nb;
         id_ff   <= id_nb;
      end
   end

   assign score      = score_ff;
   assign id         = id_ff;
   assign trav_score = trav_score_ff;
   assign trav_id    = trav_id_ff;
   assign rank       = rank_ff;
endmodule

[src/score_rank_tier_assigner_top.sv]
// Top level of the score rank tier assigner: control, accumulator and cell chain.
//
//   channel   direction  payload
//   req_chan  in         importance_value (32 bits)
//   rsp_chan  out        expert_id, tier, local_index, last_result
//   csr_chan  in         index (2 bits), data (16 bits)
//
// Requests are taken whenever the block is accumulating; the score of the current
// expert lives in one accumulator and is shifted into the cell chain when the
// expert closes. After the last expert, the ranking pass rotates all scores once
// around the ring of cells, during which no request is taken. Results then leave
// one per cycle from cell zero; a stall on rsp_chan holds the chain. Reset is
// synchronous and restores the register defaults and an empty accumulator.
module score_rank_tier_assigner_top #(
   parameter int NUM_EXPERTS = srta_pkg::NUM_EXPERTS_DEF,
   parameter int VALUE_WIDTH = srta_pkg::VALUE_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   srta_req_if.sink   req_chan,
   srta_rsp_if.source rsp_chan,
   srta_csr_if.sink   csr_chan
);
   import srta_pkg::*;

   localparam int RW = (NUM_EXPERTS > 1) ? $clog2(NUM_EXPERTS) : 1;
   localparam int CW = RW + 1;
   localparam logic [CW-1:0] LAST_CNT = CW'(NUM_EXPERTS - 1);

   // The phases of the block, one hot.
   typedef enum logic [2:0] {
      ST_ACCUM = 3'b001,
      ST_RANK  = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   vpe_ff, vpe_in;
   logic [SIZE_W-1:0]  t0_ff, t0_in, t1_ff, t1_in;
   logic [CNT_W-1:0]   vcnt_ff, vcnt_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [SCORE_W-1:0] acc_ff, acc_in;
   logic [LOCAL_W-1:0] loc_ff [3];
   logic [LOCAL_W-1:0] loc_in [3];

   logic               ov_ff, ov_in;
   logic [ID_W-1:0]    oid_ff, oid_in;
   logic [TIER_W-1:0]  otier_ff, otier_in;
   logic [LOCAL_W-1:0] oloc_ff, oloc_in;
   logic               olast_ff, olast_in;

   cell_ctl_type ctl;

   logic [SCORE_W-1:0] c_score [NUM_EXPERTS];
   logic [RW-1:0]      c_id    [NUM_EXPERTS];
   logic [SCORE_W-1:0] c_tscore[NUM_EXPERTS];
   logic [RW-1:0]      c_tid   [NUM_EXPERTS];
   logic [RW-1:0]      c_rank  [NUM_EXPERTS];

   logic               req_take;
   logic [SCORE_W-1:0] sum;
   logic [CNT_W-1:0]   vcnt_next;
   logic [CNT_W-1:0]   need;
   logic               close;
   logic               load_out;
   logic [TCMP_W-1:0]  rank_ext;
   logic [TCMP_W-1:0]  b0, b1;
   logic [TIER_W-1:0]  tier_now;
   logic [SCORE_W-1:0] in_val;

   assign req_chan.ready = (state_ff == ST_ACCUM);
   assign csr_chan.ready = 1'b1;
   assign req_take = req_chan.valid && req_chan.ready;

   // Only the low VALUE_WIDTH bits of a request count.
   assign in_val    = SCORE_W'(req_chan.importance_value[VALUE_WIDTH-1:0]);
   assign sum       = acc_ff + in_val;
   assign vcnt_next = vcnt_ff + 1'b1;
   assign need      = (vpe_ff == '0) ? CNT_W'(1) : vpe_ff;
   assign close     = (vcnt_next >= need);

   assign load_out  = (state_ff == ST_EMIT) && (!ov_ff || rsp_chan.ready);

   // Tier of the rank at cell zero; tier 1 is clipped by the running bound.
   assign rank_ext = TCMP_W'(c_rank[0]);
   assign b0       = TCMP_W'(t0_ff);
   assign b1       = TCMP_W'(t0_ff) + TCMP_W'(t1_ff);
   always_comb begin
      if (rank_ext < b0) begin
         tier_now = TIER_TOP;
      end else if (rank_ext < b1) begin
         tier_now = TIER_MID;
      end else begin
         tier_now = TIER_LOW;
      end
   end

   always_comb begin
      ctl.push   = req_take && close;
      ctl.rotate = (state_ff == ST_RANK);
      ctl.emit   = load_out;
   end

   always_comb begin
      state_in = state_ff;
      vpe_in   = vpe_ff;
      t0_in    = t0_ff;
      t1_in    = t1_ff;
      vcnt_in  = vcnt_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      loc_in   = loc_ff;
      ov_in    = ov_ff;
      oid_in   = oid_ff;
      otier_in = otier_ff;
      oloc_in  = oloc_ff;
      olast_in = olast_ff;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_VALUES_PER_EXPERT: vpe_in = csr_chan.data;
            CSR_TIER0_SIZE:        t0_in  = csr_chan.data[SIZE_W-1:0];
            CSR_TIER1_SIZE:        t1_in  = csr_chan.data[SIZE_W-1:0];
            default: ;
         endcase
      end

      if (ov_ff && rsp_chan.ready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         ST_ACCUM: begin
            if (req_take) begin
               if (close) begin
                  acc_in  = '0;
                  vcnt_in = '0;
                  if (cnt_ff == LAST_CNT) begin
                     cnt_in   = '0;
                     state_in = ST_RANK;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  acc_in  = sum;
                  vcnt_in = vcnt_next;
               end
            end
         end
         ST_RANK: begin
            if (cnt_ff == LAST_CNT) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               ov_in    = 1'b1;
               oid_in   = ID_W'(c_id[0]);
               otier_in = tier_now;
               oloc_in  = loc_ff[tier_now];
               loc_in[tier_now] = loc_ff[tier_now] + 1'b1;
               olast_in = (cnt_ff == LAST_CNT);
               if (cnt_ff == LAST_CNT) begin
                  cnt_in   = '0;
                  loc_in   = '{default: '0};
                  state_in = ST_ACCUM;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         vpe_ff   <= CNT_W'(1);
         t0_ff    <= SIZE_W'(8);
         t1_ff    <= SIZE_W'(24);
         vcnt_ff  <= '0;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         loc_ff   <= '{default: '0};
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         vpe_ff   <= vpe_in;
         t0_ff    <= t0_in;
         t1_ff    <= t1_in;
         vcnt_ff  <= vcnt_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         loc_ff   <= loc_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      oid_ff   <= oid_in;
      otier_ff <= otier_in;
      oloc_ff  <= oloc_in;
      olast_ff <= olast_in;
   end

   // The chain: finished scores enter at the high end and move toward cell zero,
   // the circulating copies wrap from cell zero back to the high end.
   for (genvar k = 0; k < NUM_EXPERTS; k++) begin : g_cell
      localparam int NB = (k == NUM_EXPERTS - 1) ? 0 : k + 1;
      logic [SCORE_W-1:0] s_nb;
      logic [RW-1:0]      i_nb;
      logic [RW-1:0]      r_nb;
      if (k == NUM_EXPERTS - 1) begin : g_end
         assign s_nb = sum;
         assign i_nb = cnt_ff[RW-1:0];
         assign r_nb = '0;
      end else begin : g_mid
         assign s_nb = c_score[k+1];
         assign i_nb = c_id[k+1];
         assign r_nb = c_rank[k+1];
      end
      srta_cell #(.RW(RW)) u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .score_nb      (s_nb),
         .id_nb         (i_nb),
         .trav_score_nb (c_tscore[NB]),
         .trav_id_nb    (c_tid[NB]),
         .rank_nb       (r_nb),
         .score         (c_score[k]),
         .id            (c_id[k]),
         .trav_score    (c_tscore[k]),
         .trav_id       (c_tid[k]),
         .rank          (c_rank[k])
      );
   end

   assign rsp_chan.valid       = ov_ff;
   assign rsp_chan.expert_id   = oid_ff;
   assign rsp_chan.tier        = otier_ff;
   assign rsp_chan.local_index = oloc_ff;
   assign rsp_chan.last_result = olast_ff;
endmodule

[src/srta_checker.sv]
// Port-level checker for the score rank tier assigner, bound to the top level.
module srta_checker (
   input logic        clock,
   input logic        reset,
   srta_req_if.sink   req_chan,
   srta_rsp_if.source rsp_chan,
   srta_csr_if.sink   csr_chan
);
   import srta_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("result dropped while stalled");

   a_no_req_mid_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last_result |-> !req_chan.ready)
      else $error("request taken while results still pending");

   a_tier_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.tier == TIER_TOP || rsp_chan.tier == TIER_MID ||
                          rsp_chan.tier == TIER_LOW))
      else $error("tier code out of range");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && csr_chan.ready)
      else $error("result shown right after reset");
endmodule

bind score_rank_tier_assigner_top srta_checker u_srta_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan),
   .csr_chan (csr_chan)
);

[verif/srta_scoreboard.sv]
// Scoreboard class that predicts tier assignments and checks results.
`timescale 1ns / 1ps
package srta_tb_pkg;
   import srta_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]    expert_id;
      logic [TIER_W-1:0]  tier;
      logic [LOCAL_W-1:0] local_index;
      logic               last_result;
   } tier_result_type;

   class tier_scoreboard;
      logic [CNT_W-1:0]   vals_per_expert;
      logic [SIZE_W-1:0]  top_size;
      logic [SIZE_W-1:0]  mid_size;
      logic [SCORE_W-1:0] scores[NUM_EXPERTS_DEF];
      int unsigned        value_cnt;
      int unsigned        expert_cnt;
      tier_result_type    pending[$];
      int                 errors;

      function void restart();
         vals_per_expert = 1;
         top_size = 8;
         mid_size = 24;
         foreach (scores[i]) scores[i] = '0;
         value_cnt = 0;
         expert_cnt = 0;
         pending.delete();
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            CSR_VALUES_PER_EXPERT: vals_per_expert = d;
            CSR_TIER0_SIZE: top_size = d[SIZE_W-1:0];
            CSR_TIER1_SIZE: mid_size = d[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function void rank_and_queue();
         int unsigned     rnk;
         int unsigned     next_local[3];
         int unsigned     t;
         tier_result_type r;
         next_local = '{0, 0, 0};
         for (int e = 0; e < NUM_EXPERTS_DEF; e++) begin
            rnk = 0;
            for (int j = 0; j < NUM_EXPERTS_DEF; j++)
               if (scores[j] > scores[e] || (scores[j] == scores[e] && j < e)) rnk++;
            if (rnk < top_size) t = TIER_TOP;
            else if (rnk < int'(top_size) + int'(mid_size)) t = TIER_MID;
            else t = TIER_LOW;
            r.expert_id = ID_W'(e);
            r.tier = TIER_W'(t);
            r.local_index = LOCAL_W'(next_local[t]);
            r.last_result = (e == NUM_EXPERTS_DEF - 1);
            next_local[t]++;
            pending = {pending, r};
         end
         foreach (scores[i]) scores[i] = '0;
         value_cnt = 0;
         expert_cnt = 0;
      endfunction

      function void note_value(logic [IN_W-1:0] v);
         int unsigned need;
         need = (vals_per_expert == 0) ? 1 : vals_per_expert;
         scores[expert_cnt] = scores[expert_cnt] + v;
         value_cnt = (value_cnt + 1) & 16'hFFFF;
         if (value_cnt >= need) begin
            value_cnt = 0;
            expert_cnt++;
            if (expert_cnt >= NUM_EXPERTS_DEF) rank_and_queue();
         end
      endfunction

      function void check_result(tier_result_type got);
         tier_result_type exp_r;
         if (pending.size() == 0) begin
            $error("unexpected result for expert %0d", got.expert_id);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.expert_id !== exp_r.expert_id) begin
            $error("expert_id expected %0d actual %0d", exp_r.expert_id, got.expert_id);
            errors++;
         end
         if (got.tier !== exp_r.tier) begin
            $error("tier expected %0d actual %0d", exp_r.tier, got.tier);
            errors++;
         end
         if (got.local_index !== exp_r.local_index) begin
            $error("local_index expected %0d actual %0d", exp_r.local_index,
                   got.local_index);
            errors++;
         end
         if (got.last_result !== exp_r.last_result) begin
            $error("last_result expected %0d actual %0d", exp_r.last_result,
                   got.last_result);
            errors++;
         end
      endfunction
   endclass
endpackage

[verif/testbench.sv]
// Top-level testbench for the score rank tier assigner.
`timescale 1ns / 1ps
module testbench;
   import srta_pkg::*;
   import srta_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srta_req_if req_chan();
   srta_rsp_if rsp_chan();
   srta_csr_if csr_chan();

   score_rank_tier_assigner_top dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   always #5 clock = ~clock;

   tier_scoreboard sb = new();
   // Cleared by the stimulus near the end so the last stretch runs without stalls.
   bit      stalls_on = 1'b1;
   longint  cycle_count = 0;
   // One data set needs up to 64 experts times values_per_expert requests plus a
   // ranking pass and 64 results; the limit leaves a wide margin over that.
   localparam longint CYCLE_LIMIT = 1500000;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.importance_value = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      rsp_chan.ready = 1'b0;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // The result side holds ready low in random bursts.
   int unsigned rsp_hold = 0;
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result('{rsp_chan.expert_id, rsp_chan.tier, rsp_chan.local_index,
                           rsp_chan.last_result});
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
         rsp_hold = $urandom_range(0, 12);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Sends one request, with a random idle burst ahead of it now and then.
   // Valid stays high afterwards so requests can follow back to back.
   task automatic send_value(logic [IN_W-1:0] v);
      if (stalls_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.importance_value <= v;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_value(v);
   endtask

   // Drops the request valid once a run of requests is over.
   task automatic req_stop();
      req_chan.valid <= 1'b0;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= d;
      do @(posedge clock); while (!csr_chan.ready);
      sb.write_reg(idx, d);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every expected result has arrived, then lets the block settle.
   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2 * NUM_EXPERTS_DEF + 10) @(posedge clock);
   endtask

   // Random value with a spread of magnitudes so ties and extremes both appear.
   function automatic logic [IN_W-1:0] pick_value();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   // Feeds one complete data set of 64 experts.
   task automatic send_set(bit random_vals);
      int unsigned need;
      need = (sb.vals_per_expert == 0) ? 1 : sb.vals_per_expert;
      for (int e = 0; e < NUM_EXPERTS_DEF; e++)
         for (int k = 0; k < need; k++)
            send_value(random_vals ? pick_value() : logic'(e[0]) ? 32'hFFFF_FFFF : 32'd0);
   endtask

   initial begin
      sb.restart();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset setting with alternating extremes, which makes many ties.
      send_set(1'b0);
      req_stop();
      drain();

      // Empty tier 0, tier 1 takes every rank and tier 2 is empty. The count is
      // zero, which acts as one.
      write_reg(CSR_TIER0_SIZE, 16'd0);
      write_reg(CSR_TIER1_SIZE, 16'd64);
      write_reg(CSR_VALUES_PER_EXPERT, 16'd0);
      send_set(1'b1);
      req_stop();
      drain();

      // Last part without any idling on either side.
      stalls_on = 1'b0;
      // High bits of the size writes are dropped; random sizes often clip tier 1.
      write_reg(CSR_TIER0_SIZE, 16'hFF80 | CSR_DATA_W'($urandom_range(0, 64)));
      write_reg(CSR_TIER1_SIZE, CSR_DATA_W'($urandom_range(0, 64)));
      // A write to an index beyond the register list must be ignored.
      write_reg(2'd3, 16'hFFFF);
      // Count lowered in the middle of the first expert: it closes on the next value.
      write_reg(CSR_VALUES_PER_EXPERT, 16'd2);
      send_value(pick_value());
      req_stop();
      write_reg(CSR_VALUES_PER_EXPERT, 16'd1);
      send_value(pick_value());
      for (int e = 1; e < NUM_EXPERTS_DEF; e++) send_value(pick_value());
      req_stop();
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

[sim.f]
src/srta_pkg.sv
src/srta_if.sv
src/srta_cell.sv
src/score_rank_tier_assigner_top.sv
src/srta_checker.sv
verif/srta_scoreboard.sv
verif/testbench.sv
